>>> hdl/cramer_3x3_linear_solver_unit_defines.svh
// Assertion macros shared by the solver checker.
`ifndef CRAMER_3X3_LINEAR_SOLVER_UNIT_DEFINES_SVH
`define CRAMER_3X3_LINEAR_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define C3LS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("c3ls check failed");

// Next-cycle implication, disabled during reset.
`define C3LS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("c3ls check failed");

`endif

>>> hdl/c3ls_pkg.sv
// Package: constants, command/status types and helpers of the 3x3 solver.
`timescale 1ns / 1ps
package c3ls_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COEFF_WIDTH = 32;
  localparam int IN_W        = 32;
  localparam int SOL_W       = 32;
  localparam int IDX_W       = 2;
  localparam int NUM_UNK     = 3;
  localparam int ROW_LEN     = NUM_UNK + 1;
  localparam int NUM_COEFF   = NUM_UNK * ROW_LEN;
  localparam int ADDR_W      = $clog2(NUM_COEFF);
  localparam int CNT_W       = 4;
  localparam int MUL_A_W     = COEFF_WIDTH + 1;
  localparam int PROD_W      = 2 * COEFF_WIDTH;
  localparam int PP_W        = 2 * COEFF_WIDTH + 1;
  localparam int ACC_W       = 3 * COEFF_WIDTH + 2;
  localparam int NUM_W       = ACC_W + FRAC_BITS;
  localparam int REM_W       = ACC_W + 1;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int TERM_LAST   = 5;
  localparam int PHASE_LAST  = 5;

  typedef enum logic [1:0] {
    MUL_XA = 2'd0,
    MUL_LO = 2'd1,
    MUL_HI = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic              st_we;
    logic [ADDR_W-1:0] st_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              ld_xa;
    logic              ld_zc;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              acc_clr;
    logic              acc_add;
    logic              acc_shift;
    logic              acc_neg;
    logic              save_main;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    logic [IDX_W-1:0]  out_idx;
    logic              out_last;
  } cmd_t;

  typedef struct packed {
    logic dmain_zero;
    logic out_busy;
  } sts_t;

  function automatic logic [ADDR_W-1:0] coef_addr(input logic [1:0] row, input logic [1:0] col);
    return ADDR_W'(int'(row) * ROW_LEN + int'(col));
  endfunction

endpackage

>>> hdl/c3ls_ifs.sv
// Valid/ready channel interfaces for coefficient input and solution output.
`timescale 1ns / 1ps
interface c3ls_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [c3ls_pkg::IN_W-1:0]    coeff_value;
  modport source (output valid, output coeff_value, input ready);
  modport sink   (input valid, input coeff_value, output ready);
endinterface

interface c3ls_out_if;
  logic                                valid;
  logic                                ready;
  logic [c3ls_pkg::IDX_W-1:0]          unknown_index;
  logic signed [c3ls_pkg::SOL_W-1:0]   solution_value;
  logic                                singular;
  logic                                last_result;
  modport source (output valid, output unknown_index, output solution_value,
                  output singular, output last_result, input ready);
  modport sink   (input valid, input unknown_index, input solution_value,
                  input singular, input last_result, output ready);
endinterface

>>> hdl/c3ls_ctrl.sv
// Sequencer: load count, determinant term walk, divider count, result issue.
`timescale 1ns / 1ps
module c3ls_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  c3ls_pkg::sts_t sts,
  output c3ls_pkg::cmd_t cmd
);
  import c3ls_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_DET   = 6'b000010,
    S_FIN   = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 main_r, main_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [2:0]           term_r, term_nxt;
  logic [2:0]           phase_r, phase_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic [1:0] col_i, col_j, col_k;
  logic       term_neg;

  function automatic logic [1:0] next_col(input logic [1:0] c);
    case (c)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // right-side column stands in for the column of the unknown being solved
  function automatic logic [1:0] map_col(input logic [1:0] c, input logic m,
                                         input logic [1:0] k);
    return (!m && c == k) ? 2'(NUM_UNK) : c;
  endfunction

  assign col_i    = term_r[2:1];
  assign col_j    = next_col(col_i);
  assign col_k    = next_col(col_j);
  assign term_neg = term_r[0];

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    main_nxt    = main_r;
    k_nxt       = k_r;
    term_nxt    = term_r;
    phase_nxt   = phase_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready     = 1'b1;
        cmd.st_addr  = cnt_r[ADDR_W-1:0];
        if (in_valid) begin
          cmd.st_we = 1'b1;
          if (cnt_r == CNT_W'(NUM_COEFF - 1)) begin
            cnt_nxt     = '0;
            main_nxt    = 1'b1;
            k_nxt       = '0;
            term_nxt    = '0;
            phase_nxt   = '0;
            cmd.acc_clr = 1'b1;
            state_nxt   = S_DET;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      S_DET: begin
        case (phase_r)
          3'd0: begin
            cmd.rd_addr = coef_addr(2'd1, map_col(term_neg ? col_k : col_j, main_r, k_r));
            cmd.ld_xa   = 1'b1;
          end
          3'd1: begin
            cmd.rd_addr = coef_addr(2'd2, map_col(term_neg ? col_j : col_k, main_r, k_r));
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_XA;
          end
          3'd2: begin
            cmd.rd_addr = coef_addr(2'd0, map_col(col_i, main_r, k_r));
            cmd.ld_zc   = 1'b1;
          end
          3'd3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_LO;
          end
          3'd4: begin
            cmd.acc_add = 1'b1;
            cmd.acc_neg = term_neg;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_HI;
          end
          default: begin
            cmd.acc_add   = 1'b1;
            cmd.acc_shift = 1'b1;
            cmd.acc_neg   = term_neg;
          end
        endcase
        if (phase_r == 3'(PHASE_LAST)) begin
          phase_nxt = '0;
          term_nxt  = term_r + 3'd1;
          if (term_r == 3'(TERM_LAST)) begin
            term_nxt  = '0;
            state_nxt = S_FIN;
          end
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end
      S_FIN: begin
        if (main_r) begin
          cmd.save_main = 1'b1;
          state_nxt     = S_CHECK;
        end else begin
          cmd.div_init = 1'b1;
          div_cnt_nxt  = '0;
          state_nxt    = S_DIV;
        end
      end
      S_CHECK: begin
        k_nxt = '0;
        if (sts.dmain_zero) begin
          state_nxt = S_EMIT;
        end else begin
          main_nxt    = 1'b0;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_DET;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end
      end
      S_EMIT: begin
        cmd.out_idx  = k_r;
        cmd.out_last = (k_r == 2'(NUM_UNK - 1));
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          if (k_r == 2'(NUM_UNK - 1)) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt = k_r + 2'd1;
            if (!sts.dmain_zero) begin
              cmd.acc_clr = 1'b1;
              state_nxt   = S_DET;
            end
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      main_r    <= 1'b1;
      k_r       <= '0;
      term_r    <= '0;
      phase_r   <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      main_r    <= main_nxt;
      k_r       <= k_nxt;
      term_r    <= term_nxt;
      phase_r   <= phase_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

>>> hdl/c3ls_datapath.sv
// Datapath: coefficient store, shared multiplier, accumulator, divider, output word.
`timescale 1ns / 1ps
module c3ls_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [c3ls_pkg::IN_W-1:0] in_data,
  input  c3ls_pkg::cmd_t                  cmd,
  output c3ls_pkg::sts_t                  sts,
  c3ls_out_if.source                      out_ch
);
  import c3ls_pkg::*;

  logic        [COEFF_WIDTH-1:0] coef_r [NUM_COEFF];
  logic signed [COEFF_WIDTH-1:0] rd_data;
  logic signed [COEFF_WIDTH-1:0] xa_r, zc_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PP_W-1:0]        pp_r;
  logic signed [ACC_W-1:0]       acc_r, dmain_r, acc_term;
  logic signed [MUL_A_W-1:0]     op_a;
  logic signed [COEFF_WIDTH-1:0] op_b;
  logic signed [PP_W-1:0]        mul_out;

  logic [ACC_W-1:0] acc_mag, den_mag;
  logic [NUM_W-1:0] num_r, q_r, lim, mag_w;
  logic [REM_W-1:0] rem_r, rem_sh;
  logic             neg_r, ge;
  logic signed [COEFF_WIDTH-1:0] sat_val;

  logic                          out_valid_r;
  logic [IDX_W-1:0]              out_idx_r;
  logic signed [COEFF_WIDTH-1:0] out_sol_r;
  logic                          out_sing_r, out_last_r;

  assign rd_data = coef_r[cmd.rd_addr];

  always_ff @(posedge clk) begin
    if (cmd.st_we) coef_r[cmd.st_addr] <= in_data[COEFF_WIDTH-1:0];
  end

  // single signed multiplier, operands picked per phase
  always_comb begin
    case (cmd.mul_sel)
      MUL_XA: begin
        op_a = MUL_A_W'(xa_r);
        op_b = rd_data;
      end
      MUL_LO: begin
        op_a = {1'b0, prod_r[COEFF_WIDTH-1:0]};
        op_b = zc_r;
      end
      MUL_HI: begin
        op_a = MUL_A_W'(signed'(prod_r[PROD_W-1:COEFF_WIDTH]));
        op_b = zc_r;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_out  = PP_W'(op_a) * PP_W'(op_b);
  assign acc_term = cmd.acc_shift ? (ACC_W'(pp_r) <<< COEFF_WIDTH) : ACC_W'(pp_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_xa) xa_r <= rd_data;
    if (cmd.ld_zc) zc_r <= rd_data;
    if (cmd.mul_en) begin
      if (cmd.mul_sel == MUL_XA) prod_r <= mul_out[PROD_W-1:0];
      else                       pp_r   <= mul_out;
    end
    if (cmd.acc_clr)      acc_r <= '0;
    else if (cmd.acc_add) acc_r <= cmd.acc_neg ? acc_r - acc_term : acc_r + acc_term;
    if (cmd.save_main) dmain_r <= acc_r;
  end

  // restoring divider, one quotient bit per cycle
  assign acc_mag = acc_r[ACC_W-1]   ? ACC_W'(-acc_r)   : ACC_W'(acc_r);
  assign den_mag = dmain_r[ACC_W-1] ? ACC_W'(-dmain_r) : ACC_W'(dmain_r);
  assign rem_sh  = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
  assign ge      = rem_sh >= REM_W'(den_mag);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num_r <= NUM_W'(acc_mag) << FRAC_BITS;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= acc_r[ACC_W-1] ^ dmain_r[ACC_W-1];
    end else if (cmd.div_step) begin
      num_r <= num_r << 1;
      rem_r <= ge ? rem_sh - REM_W'(den_mag) : rem_sh;
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  // saturate quotient magnitude to the signed coefficient range
  assign lim     = neg_r ? (NUM_W'(1) << (COEFF_WIDTH - 1))
                         : ((NUM_W'(1) << (COEFF_WIDTH - 1)) - NUM_W'(1));
  assign mag_w   = (q_r > lim) ? lim : q_r;
  assign sat_val = neg_r ? -signed'(mag_w[COEFF_WIDTH-1:0]) : signed'(mag_w[COEFF_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_idx_r  <= cmd.out_idx;
      out_last_r <= cmd.out_last;
      out_sing_r <= sts.dmain_zero;
      out_sol_r  <= sts.dmain_zero ? '0 : sat_val;
    end
  end

  assign sts.dmain_zero = (dmain_r == '0);
  assign sts.out_busy   = out_valid_r & ~out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.unknown_index  = out_idx_r;
  assign out_ch.solution_value = SOL_W'(out_sol_r);
  assign out_ch.singular       = out_sing_r;
  assign out_ch.last_result    = out_last_r;

endmodule

>>> hdl/cramer_3x3_linear_solver_unit.sv
// Top level: 3x3 Cramer's-rule solver, sequencer plus datapath.
`timescale 1ns / 1ps
// Load: one coefficient word per cycle, twelve words per system.
// After the twelfth word: the main determinant, then per unknown a determinant
// on the shared multiplier and 114 one-bit divider steps; results issue x, y, z
// in that order. Singular: all three issue straight after the main determinant.
// No new system is taken until z issues: the multiplier walk and serial divider set the rate.
// Reset (sync, rst_n low): load count, sequencer and output valid cleared.
module cramer_3x3_linear_solver_unit (
  input  logic        clk,
  input  logic        rst_n,
  c3ls_in_if.sink     in_ch,
  c3ls_out_if.source  out_ch
);
  import c3ls_pkg::*;

  cmd_t cmd;   // per-cycle datapath command
  sts_t sts;   // singular flag and output-word backpressure

  // Sequencer: owns the input handshake, walks the 6 terms x 6 phases of
  // each determinant, counts divider steps and issues the three results.
  c3ls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: store, exact wide accumulation, divider, saturation and the
  // output word register that decouples the result side.
  c3ls_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_ch.coeff_value),
    .cmd     (cmd),
    .sts     (sts),
    .out_ch  (out_ch)
  );

endmodule

>>> hdl/c3ls_chk.sv
// Port-level checker for the solver, bound to the top level.
`timescale 1ns / 1ps
`include "cramer_3x3_linear_solver_unit_defines.svh"
module c3ls_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [c3ls_pkg::IDX_W-1:0]      out_unknown_index,
  input logic signed [c3ls_pkg::SOL_W-1:0] out_solution_value,
  input logic                            out_singular,
  input logic                            out_last_result
);
  import c3ls_pkg::*;

  `C3LS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_unknown_index) && $stable(out_solution_value) && $stable(out_singular) && $stable(out_last_result))
  `C3LS_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && out_singular, out_solution_value == '0)
  `C3LS_ASSERT_IMP(a_last_is_z, clk, rst_n, out_valid && out_last_result, out_unknown_index == IDX_W'(NUM_UNK - 1))
  `C3LS_ASSERT_IMP(a_no_load_mid_run, clk, rst_n, out_valid && !out_last_result, !in_ready)

endmodule

bind cramer_3x3_linear_solver_unit c3ls_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_unknown_index  (out_ch.unknown_index),
  .out_solution_value (out_ch.solution_value),
  .out_singular       (out_ch.singular),
  .out_last_result    (out_ch.last_result)
);

>>> sim/cramer_3x3_linear_solver_unit_test.sv
// Testbench for the 3x3 Cramer's-rule solver: directed and random systems, scored per word.
`timescale 1ns / 1ps
module cramer_3x3_linear_solver_unit_test;
  import c3ls_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [SOL_W-1:0] value;
    logic             sing;
    logic             last;
  } solution_t;

  logic clk;
  logic rst_n;
  c3ls_in_if  in_ch ();
  c3ls_out_if out_ch ();

  cramer_3x3_linear_solver_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predictor state
  logic signed [COEFF_WIDTH-1:0] coeff_mem [NUM_COEFF];
  int unsigned                   coeffs_loaded;
  solution_t                     solutions_due [$];

  int  mismatch_count = 0;
  int  stall_cycles = 0;
  bit  calm;          // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // 3x3 determinant with the right side substituted into column rhs_col (3 = none)
  function automatic logic signed [127:0] det_with_rhs(input int rhs_col);
    logic signed [127:0] m [3][3];
    logic signed [127:0] acc;
    acc = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = (c == rhs_col) ? 128'(coeff_mem[r*ROW_LEN+3]) : 128'(coeff_mem[r*ROW_LEN+c]);
    for (int i = 0; i < 3; i++)
      acc += m[0][i] * (m[1][(i+1)%3] * m[2][(i+2)%3] - m[1][(i+2)%3] * m[2][(i+1)%3]);
    return acc;
  endfunction

  // (num << FRAC_BITS) / den, truncated toward zero and saturated
  function automatic logic [SOL_W-1:0] fixed_quotient(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
    logic        neg;
    logic [127:0] n_mag, d_mag, q;
    neg   = num[127] ^ den[127];
    n_mag = num[127] ? -num : num;
    d_mag = den[127] ? -den : den;
    n_mag = n_mag << FRAC_BITS;   // |num| < 2^98, fits
    q     = n_mag / d_mag;
    if (!neg && q > 128'h7fff_ffff) return 32'h7fff_ffff;
    if (neg && q > 128'h8000_0000)  return 32'h8000_0000;
    return neg ? SOL_W'(-q) : SOL_W'(q);
  endfunction

  // models one accepted coefficient word
  task automatic predict_word(input logic [IN_W-1:0] w);
    logic signed [127:0] dmain;
    solution_t s;
    if (coeffs_loaded >= NUM_COEFF) coeffs_loaded = 0;
    coeff_mem[coeffs_loaded] = w[COEFF_WIDTH-1:0];
    coeffs_loaded++;
    if (coeffs_loaded < NUM_COEFF) return;
    coeffs_loaded = 0;
    dmain = det_with_rhs(3);
    for (int k = 0; k < NUM_UNK; k++) begin
      s.idx   = IDX_W'(k);
      s.sing  = (dmain == 0);
      s.value = s.sing ? '0 : fixed_quotient(det_with_rhs(k), dmain);
      s.last  = (k == NUM_UNK - 1);
      solutions_due.push_back(s);
    end
  endtask

  // drop valid when the sender stops
  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  // valid stays up after an accept so back-to-back words need one drive per edge
  task automatic send_word(input logic [IN_W-1:0] w);
    while (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.coeff_value <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_word(w);
  endtask

  task automatic send_system(input logic [IN_W-1:0] w [NUM_COEFF]);
    for (int i = 0; i < NUM_COEFF; i++) send_word(w[i]);
  endtask

  function automatic logic [IN_W-1:0] rand_coeff();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8)) - 4) << FRAC_BITS;
      2: return {{14{1'b0}}, 18'($urandom)} ^ {32{$urandom_range(1) == 1}};
      3: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(200)) - 100) << ($urandom_range(20));
    endcase
  endfunction

  task automatic wait_drained();
    idle_input();
    while (solutions_due.size() != 0) @(posedge clk);
  endtask

  // identity system, integer and fractional right sides
  task automatic test_identity();
    logic [IN_W-1:0] w [NUM_COEFF];
    w = '{32'h10000, 0, 0, 32'h30000, 0, 32'h10000, 0, 32'hfffe8000,
          0, 0, 32'h10000, 32'h00004000};
    send_system(w);
  endtask

  // main determinant zero: every unknown flagged singular
  task automatic test_singular();
    logic [IN_W-1:0] w [NUM_COEFF];
    w = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h40000, 32'h60000,
          32'h7fffffff, 0, 0, 0, 32'h80000000};
    send_system(w);
  endtask

  // tiny determinant, huge right side: saturates both ways
  task automatic test_saturation();
    logic [IN_W-1:0] w [NUM_COEFF];
    w = '{32'h1, 0, 0, 32'h7fffffff, 0, 32'hffffffff, 0, 32'h7fffffff,
          0, 0, 32'h1, 32'h80000000};
    send_system(w);
  endtask

  // field extremes everywhere, large determinants and rounding toward zero
  task automatic test_extremes();
    logic [IN_W-1:0] w [NUM_COEFF];
    w = '{32'h80000000, 32'h7fffffff, 32'h12345678, 32'h80000000,
          32'h7fffffff, 32'h80000000, 32'hedcba987, 32'hffffffff,
          32'h00000001, 32'h55555555, 32'haaaaaaaa, 32'h7fffffff};
    send_system(w);
  endtask

  // a partial run gives no word; it completes on the following words
  task automatic test_partial_run();
    for (int i = 0; i < 5; i++) send_word(rand_coeff());
    calm = 1'b0;
    idle_input();
    repeat (50) @(posedge clk);
    for (int i = 0; i < 7; i++) send_word(32'($signed($urandom_range(6)) - 3) << FRAC_BITS);
  endtask

  // random systems, a few singular ones mixed in
  task automatic test_random(input int systems);
    logic [IN_W-1:0] w [NUM_COEFF];
    for (int s = 0; s < systems; s++) begin
      for (int i = 0; i < NUM_COEFF; i++) w[i] = rand_coeff();
      if ($urandom_range(5) == 0)
        for (int c = 0; c < 4; c++) w[8+c] = w[4+c];   // repeated row
      calm = (s >= systems - 2);
      send_system(w);
    end
  endtask

  // result scoreboard and sink-side stalls
  always @(posedge clk) begin
    solution_t s;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (solutions_due.size() == 0) begin
        report_mismatch("unexpected word", 64'($unsigned(out_ch.solution_value)), '0);
      end else begin
        s = solutions_due.pop_front();
        if (out_ch.unknown_index !== s.idx)
          report_mismatch("unknown_index", 64'(out_ch.unknown_index), 64'(s.idx));
        if (out_ch.solution_value !== s.value)
          report_mismatch("solution_value", 64'($unsigned(out_ch.solution_value)),
                          64'(s.value));
        if (out_ch.singular !== s.sing)
          report_mismatch("singular", 64'(out_ch.singular), 64'(s.sing));
        if (out_ch.last_result !== s.last)
          report_mismatch("last_result", 64'(out_ch.last_result), 64'(s.last));
      end
    end
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.coeff_value = '0;
    calm              = 1'b0;
    coeffs_loaded     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity();
    test_singular();
    wait_drained();          // sender holds until every word is back
    test_saturation();
    test_extremes();
    calm = 1'b1;
    test_partial_run();
    test_random(5);

    wait_drained();
    repeat (600) @(posedge clk);
    if (mismatch_count == 0 && solutions_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
